// ===== hdl/stack_machine_execute_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Stack machine execute unit assertion macros
// Clocked assertion shorthands on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that an expression holds at every edge
`define SME_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Check that a condition implies another at the same edge
`define SME_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that a condition implies another at the next edge
`define SME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SME_ASSERT_ALWAYS(lbl, expr, msg)
`define SME_ASSERT_IMPL(lbl, ante, cons, msg)
`define SME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Shared constants, opcodes, status codes and payload types.
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam int STACK_ENTRIES = 1024;
	localparam int ADDR_W        = $clog2(STACK_ENTRIES);
	localparam int CNT_W         = $clog2(STACK_ENTRIES + 1);
	localparam int DATA_W        = 32;
	localparam int DIV_STEPS     = DATA_W;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
	// Queue depth must be a power of two so the pointers wrap on their own
	localparam int QUEUE_DEPTH   = 2;
	localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		OP_PUSH    = 4'd0,
		OP_DUP     = 4'd1,
		OP_SWAP    = 4'd2,
		OP_DISCARD = 4'd3,
		OP_COPY    = 4'd4,
		OP_SLIDE   = 4'd5,
		OP_ADD     = 4'd6,
		OP_SUB     = 4'd7,
		OP_MUL     = 4'd8,
		OP_DIV     = 4'd9,
		OP_MOD     = 4'd10,
		OP_EMIT    = 4'd11,
		OP_NOP     = 4'd12
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FEW     = 3'd1,
		ST_FULL    = 3'd2,
		ST_RANGE   = 3'd3,
		ST_DIVZERO = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_DIVF
	} state_t;

	typedef struct packed {
		logic [3:0]               cmd;
		logic signed [DATA_W-1:0] operand;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]               status;
		logic                     emitted;
		logic signed [DATA_W-1:0] emit_value;
		logic signed [DATA_W-1:0] top_value;
		logic [10:0]              stack_level;
	} res_item_t;

	// Classified instruction handed from front to back
	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] operand;
		logic              opd_neg;
		logic              opd_zero;
	} dec_item_t;

	typedef struct packed {
		logic      valid;
		dec_item_t item;
	} queue_head_t;

endpackage

// ===== hdl/sme_front.sv =====
// ----------------------------------------------------------------------------
// Stack machine front end
// Accepts requests, decodes the command class and queues them for the back.
// ----------------------------------------------------------------------------
module sme_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  sme_pkg::cmd_item_t   cmd_item,
	output sme_pkg::queue_head_t head,
	input  logic                 pop
);

	sme_pkg::dec_item_t                    entry_q [sme_pkg::QUEUE_DEPTH];
	logic [sme_pkg::QUEUE_CNT_W-1:0]       cnt_q;
	logic [sme_pkg::QUEUE_PTR_W-1:0]       wr_ptr_q;
	logic [sme_pkg::QUEUE_PTR_W-1:0]       rd_ptr_q;
	sme_pkg::dec_item_t                    dec;
	logic                                  push;
	logic                                  do_pop;

	// Decode the command into its class and flag the operand
	always_comb begin
		dec.operand  = cmd_item.operand;
		dec.opd_neg  = cmd_item.operand[sme_pkg::DATA_W-1];
		dec.opd_zero = (cmd_item.operand == '0);
		unique case (cmd_item.cmd)
			4'd0:    dec.op = sme_pkg::OP_PUSH;
			4'd1:    dec.op = sme_pkg::OP_DUP;
			4'd2:    dec.op = sme_pkg::OP_SWAP;
			4'd3:    dec.op = sme_pkg::OP_DISCARD;
			4'd4:    dec.op = sme_pkg::OP_COPY;
			4'd5:    dec.op = sme_pkg::OP_SLIDE;
			4'd6:    dec.op = sme_pkg::OP_ADD;
			4'd7:    dec.op = sme_pkg::OP_SUB;
			4'd8:    dec.op = sme_pkg::OP_MUL;
			4'd9:    dec.op = sme_pkg::OP_DIV;
			4'd10:   dec.op = sme_pkg::OP_MOD;
			4'd11:   dec.op = sme_pkg::OP_EMIT;
			default: dec.op = sme_pkg::OP_NOP;
		endcase
	end

	assign cmd_ready  = (cnt_q != sme_pkg::QUEUE_CNT_W'(sme_pkg::QUEUE_DEPTH));
	assign push       = cmd_valid && cmd_ready;
	assign head.valid = (cnt_q != '0);
	assign head.item  = entry_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// Store decoded requests
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/sme_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/sme_divider.sv =====
// ----------------------------------------------------------------------------
// Stack machine divider
// Signed 32-bit divide or remainder, one restoring step per cycle.
// ----------------------------------------------------------------------------
module sme_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sme_pkg::DATA_W-1:0] dividend,
	input  logic [sme_pkg::DATA_W-1:0] divisor,
	input  logic                      want_rem,
	output logic                      done,
	output logic [sme_pkg::DATA_W-1:0] result
);

	logic                              busy_q;
	logic                              done_q;
	logic [sme_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [sme_pkg::DATA_W-1:0]        rem_q;
	logic [sme_pkg::DATA_W-1:0]        quo_q;
	logic [sme_pkg::DATA_W-1:0]        dvs_q;
	logic                              neg_q;
	logic                              rem_sel_q;
	logic [sme_pkg::DATA_W:0]          shifted;
	logic [sme_pkg::DATA_W:0]          diff;
	logic [sme_pkg::DATA_W-1:0]        abs_a;
	logic [sme_pkg::DATA_W-1:0]        abs_b;

	assign abs_a   = dividend[sme_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign abs_b   = divisor[sme_pkg::DATA_W-1] ? (~divisor + 1'b1) : divisor;
	assign shifted = {rem_q, quo_q[sme_pkg::DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	// Control: step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sme_pkg::DIV_CNT_W'(sme_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load magnitudes, then one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= abs_a;
			dvs_q     <= abs_b;
			rem_sel_q <= want_rem;
			neg_q     <= want_rem ? dividend[sme_pkg::DATA_W-1]
				: (dividend[sme_pkg::DATA_W-1] ^ divisor[sme_pkg::DATA_W-1]);
		end else if (busy_q) begin
			if (!diff[sme_pkg::DATA_W]) begin
				rem_q <= diff[sme_pkg::DATA_W-1:0];
				quo_q <= {quo_q[sme_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[sme_pkg::DATA_W-1:0];
				quo_q <= {quo_q[sme_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	// Apply sign to the selected result
	always_comb begin
		if (rem_sel_q) begin
			result = neg_q ? (~rem_q + 1'b1) : rem_q;
		end else begin
			result = neg_q ? (~quo_q + 1'b1) : quo_q;
		end
	end

	assign done = done_q;

endmodule

// ===== hdl/sme_back.sv =====
// ----------------------------------------------------------------------------
// Stack machine back end
// Executes queued instructions on the stack RAM and a top-of-stack register.
// ----------------------------------------------------------------------------
`include "stack_machine_execute_unit_defines.svh"

module sme_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sme_pkg::queue_head_t head,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_ready,
	output sme_pkg::res_item_t   res_item
);

	sme_pkg::state_t                 state_q;
	sme_pkg::state_t                 state_d;
	sme_pkg::dec_item_t              cur_q;
	logic [sme_pkg::CNT_W-1:0]       count_q;
	logic [sme_pkg::DATA_W-1:0]      top_q;
	logic [sme_pkg::ADDR_W-1:0]      rd_addr_q;
	logic                            out_valid_q;
	sme_pkg::res_item_t              out_q;

	logic                            out_free;
	logic [sme_pkg::ADDR_W-1:0]      raddr;
	logic [sme_pkg::ADDR_W-1:0]      head_addr;
	logic [sme_pkg::DATA_W-1:0]      rdata;
	logic                            we;
	logic [sme_pkg::ADDR_W-1:0]      waddr;
	logic [sme_pkg::DATA_W-1:0]      wdata;

	logic [sme_pkg::CNT_W-1:0]       n;
	logic                            is_full;
	logic                            lt_two;
	logic [sme_pkg::DATA_W-1:0]      n_ext;
	logic [sme_pkg::DATA_W-1:0]      mul_res;

	sme_pkg::status_t                st;
	logic [sme_pkg::CNT_W-1:0]       nxt_n;
	logic [sme_pkg::DATA_W-1:0]      nxt_top;
	logic                            emitted;
	logic [sme_pkg::DATA_W-1:0]      emit_value;
	logic                            div_start;
	logic                            div_done;
	logic [sme_pkg::DATA_W-1:0]      div_res;
	logic                            commit;

	assign n        = count_q;
	assign is_full  = (n >= sme_pkg::CNT_W'(sme_pkg::STACK_ENTRIES));
	assign lt_two   = (n < sme_pkg::CNT_W'(2));
	assign n_ext    = sme_pkg::DATA_W'(n);
	assign out_free = !out_valid_q || res_ready;
	assign mul_res  = top_q * rdata;

	// Address for the read of the head instruction
	always_comb begin
		if (head.item.op == sme_pkg::OP_COPY) begin
			head_addr = sme_pkg::ADDR_W'(n - sme_pkg::CNT_W'(1)
				- head.item.operand[sme_pkg::CNT_W-1:0]);
		end else begin
			head_addr = sme_pkg::ADDR_W'(n - sme_pkg::CNT_W'(2));
		end
	end

	assign raddr = (state_q == sme_pkg::S_IDLE) ? head_addr : rd_addr_q;

	sme_ram #(
		.WIDTH (sme_pkg::DATA_W),
		.DEPTH (sme_pkg::STACK_ENTRIES)
	) u_stack_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	sme_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rdata),
		.divisor  (top_q),
		.want_rem (cur_q.op == sme_pkg::OP_MOD),
		.done     (div_done),
		.result   (div_res)
	);

	// Execute: status, new level, new top, stack write
	always_comb begin
		st         = sme_pkg::ST_OK;
		nxt_n      = n;
		nxt_top    = top_q;
		emitted    = 1'b0;
		emit_value = '0;
		we         = 1'b0;
		waddr      = sme_pkg::ADDR_W'(n - sme_pkg::CNT_W'(1));
		wdata      = top_q;
		div_start  = 1'b0;
		unique case (cur_q.op)
			sme_pkg::OP_PUSH: begin
				if (is_full) begin
					st = sme_pkg::ST_FULL;
				end else begin
					we      = (n != '0);
					nxt_top = cur_q.operand;
					nxt_n   = n + 1'b1;
				end
			end
			sme_pkg::OP_DUP: begin
				if (n == '0) begin
					st = sme_pkg::ST_FEW;
				end else if (is_full) begin
					st = sme_pkg::ST_FULL;
				end else begin
					we    = 1'b1;
					nxt_n = n + 1'b1;
				end
			end
			sme_pkg::OP_SWAP: begin
				if (lt_two) begin
					st = sme_pkg::ST_FEW;
				end else begin
					we      = 1'b1;
					waddr   = sme_pkg::ADDR_W'(n - sme_pkg::CNT_W'(2));
					nxt_top = rdata;
				end
			end
			sme_pkg::OP_DISCARD: begin
				if (n == '0) begin
					st = sme_pkg::ST_FEW;
				end else begin
					nxt_top = rdata;
					nxt_n   = n - 1'b1;
				end
			end
			sme_pkg::OP_COPY: begin
				if (n == '0) begin
					st = sme_pkg::ST_FEW;
				end else if (cur_q.opd_neg || (cur_q.operand >= n_ext)) begin
					st = sme_pkg::ST_RANGE;
				end else if (is_full) begin
					st = sme_pkg::ST_FULL;
				end else begin
					we      = 1'b1;
					nxt_top = cur_q.opd_zero ? top_q : rdata;
					nxt_n   = n + 1'b1;
				end
			end
			sme_pkg::OP_SLIDE: begin
				if (cur_q.opd_zero) begin
					st = sme_pkg::ST_OK;
				end else if (cur_q.opd_neg) begin
					st = sme_pkg::ST_RANGE;
				end else if (n == '0) begin
					st = sme_pkg::ST_FEW;
				end else if (cur_q.operand > (n_ext - 1'b1)) begin
					st = sme_pkg::ST_RANGE;
				end else begin
					nxt_n = n - cur_q.operand[sme_pkg::CNT_W-1:0];
				end
			end
			sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL: begin
				if (lt_two) begin
					st = sme_pkg::ST_FEW;
				end else begin
					nxt_n = n - 1'b1;
					case (cur_q.op)
						sme_pkg::OP_ADD: nxt_top = rdata + top_q;
						sme_pkg::OP_SUB: nxt_top = rdata - top_q;
						default:         nxt_top = mul_res;
					endcase
				end
			end
			sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
				if (lt_two) begin
					st = sme_pkg::ST_FEW;
				end else if (top_q == '0) begin
					st = sme_pkg::ST_DIVZERO;
				end else begin
					div_start = (state_q == sme_pkg::S_EXEC);
					nxt_top   = div_res;
					nxt_n     = n - 1'b1;
				end
			end
			sme_pkg::OP_EMIT: begin
				if (n == '0) begin
					st = sme_pkg::ST_FEW;
				end else begin
					emitted    = 1'b1;
					emit_value = top_q;
					nxt_top    = rdata;
					nxt_n      = n - 1'b1;
				end
			end
			default: begin
				st = sme_pkg::ST_OK;
			end
		endcase
		if (!((state_q == sme_pkg::S_EXEC) && out_free && !div_start)) begin
			we = 1'b0;
		end
	end

	// Sequence: read, execute, divide, wait for output slot
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		commit  = 1'b0;
		unique case (state_q)
			sme_pkg::S_IDLE: begin
				if (head.valid) begin
					pop     = 1'b1;
					state_d = sme_pkg::S_EXEC;
				end
			end
			sme_pkg::S_EXEC: begin
				if (div_start) begin
					state_d = sme_pkg::S_DIV;
				end else if (out_free) begin
					commit  = 1'b1;
					state_d = sme_pkg::S_IDLE;
				end
			end
			sme_pkg::S_DIV: begin
				if (div_done) begin
					state_d = sme_pkg::S_DIVF;
				end
			end
			sme_pkg::S_DIVF: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = sme_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sme_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sme_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the current instruction and its read address
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q     <= head.item;
			rd_addr_q <= head_addr;
		end
	end

	// Commit stack level, top entry and the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				count_q     <= nxt_n;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			top_q                <= nxt_top;
			out_q.status         <= st;
			out_q.emitted        <= emitted;
			out_q.emit_value     <= emit_value;
			out_q.top_value      <= (nxt_n == '0) ? '0 : nxt_top;
			out_q.stack_level    <= 11'(nxt_n);
		end
	end

	assign res_valid = out_valid_q;
	assign res_item  = out_q;

	`SME_ASSERT_ALWAYS(a_level_bound, count_q <= sme_pkg::CNT_W'(sme_pkg::STACK_ENTRIES), "stack level beyond capacity")
	`SME_ASSERT_IMPL(a_commit_state, commit, (state_q == sme_pkg::S_EXEC) || (state_q == sme_pkg::S_DIVF), "commit outside execute")
	`SME_ASSERT_NEXT(a_div_start, div_start, state_q == sme_pkg::S_DIV, "divider start without divide state")
	`SME_ASSERT_IMPL(a_no_write_dividing, (state_q == sme_pkg::S_DIV) || (state_q == sme_pkg::S_DIVF), !we, "stack write during divide")

endmodule

// ===== hdl/stack_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Data stack and ALU executing one decoded stack instruction per request.
// ----------------------------------------------------------------------------
// Each request yields one result. A non-dividing instruction passes through
// two back-end states (one stack RAM read, then execute and write), set by the
// single read port of the stack RAM; divide and modulo add two divide states,
// set by the bit-serial divider that retires one quotient bit per cycle. A
// two-entry queue after the input decoder lets requests arrive while the back
// end works, and an output register holds a result while the next request is
// taken. The stack RAM needs no clearing after reset.
module stack_machine_execute_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  sme_pkg::cmd_item_t cmd_item,
	output logic               res_valid,
	input  logic               res_ready,
	output sme_pkg::res_item_t res_item
);

	sme_pkg::queue_head_t head;
	logic                 pop;

	sme_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_item  (cmd_item),
		.head      (head),
		.pop       (pop)
	);

	sme_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

// ===== tb/tb_stack_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit testbench
// Drives stack instructions through the request channel and compares every
// result with a behavioral stack model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_stack_machine_execute_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import sme_pkg::*;

	// Behavioral stack model and queue of expected results
	class stack_scoreboard;
		logic [31:0] words[STACK_ENTRIES];
		int unsigned level;
		res_item_t   pending[$];
		int          errors;

		function new();
			level = 0;
			errors = 0;
		endfunction

		function logic [31:0] div_mod(logic [31:0] a, logic [31:0] b, bit rem);
			logic [31:0] ua, ub, q, r;
			ua = a[31] ? -a : a;
			ub = b[31] ? -b : b;
			q = ua / ub;
			r = ua % ub;
			if (rem)
				return a[31] ? -r : r;
			return (a[31] ^ b[31]) ? -q : q;
		endfunction

		// Execute one request on the model and queue its result
		function void note_request(cmd_item_t req);
			int unsigned n;
			logic [31:0] opd, a, b, r, t;
			res_item_t res;
			n = level;
			opd = req.operand;
			res = '0;
			case (req.cmd)
				OP_PUSH: begin
					if (n >= STACK_ENTRIES) res.status = ST_FULL;
					else begin
						words[n] = opd;
						n++;
					end
				end
				OP_DUP: begin
					if (n == 0) res.status = ST_FEW;
					else if (n >= STACK_ENTRIES) res.status = ST_FULL;
					else begin
						words[n] = words[n-1];
						n++;
					end
				end
				OP_SWAP: begin
					if (n < 2) res.status = ST_FEW;
					else begin
						t = words[n-1];
						words[n-1] = words[n-2];
						words[n-2] = t;
					end
				end
				OP_DISCARD: begin
					if (n == 0) res.status = ST_FEW;
					else n--;
				end
				OP_COPY: begin
					if (n == 0) res.status = ST_FEW;
					else if (opd[31] || opd >= n) res.status = ST_RANGE;
					else if (n >= STACK_ENTRIES) res.status = ST_FULL;
					else begin
						words[n] = words[n-1-opd];
						n++;
					end
				end
				OP_SLIDE: begin
					if (opd == 0) ;
					else if (opd[31]) res.status = ST_RANGE;
					else if (n == 0) res.status = ST_FEW;
					else if (opd > n - 1) res.status = ST_RANGE;
					else begin
						t = words[n-1];
						n -= opd;
						words[n-1] = t;
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
					if (n < 2) res.status = ST_FEW;
					else begin
						b = words[n-1];
						a = words[n-2];
						if ((req.cmd == OP_DIV || req.cmd == OP_MOD) && b == 0)
							res.status = ST_DIVZERO;
						else begin
							case (req.cmd)
								OP_ADD: r = a + b;
								OP_SUB: r = a - b;
								OP_MUL: r = a * b;
								default: r = div_mod(a, b, req.cmd == OP_MOD);
							endcase
							n--;
							words[n-1] = r;
						end
					end
				end
				OP_EMIT: begin
					if (n == 0) res.status = ST_FEW;
					else begin
						n--;
						res.emitted = 1'b1;
						res.emit_value = words[n];
					end
				end
				default: ;
			endcase
			level = n;
			res.top_value = (n == 0) ? '0 : words[n-1];
			res.stack_level = 11'(n);
			pending.push_back(res);
		endfunction

		// Compare one result with the oldest expectation
		function void check_result(res_item_t act);
			res_item_t exp_res;
			if (pending.size() == 0) begin
				$display("%t: unexpected result %p", $realtime, act);
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			if (act.status !== exp_res.status) begin
				$display("%t: status expected %0d actual %0d", $realtime,
					exp_res.status, act.status);
				errors++;
			end
			if (act.emitted !== exp_res.emitted) begin
				$display("%t: emitted expected %0d actual %0d", $realtime,
					exp_res.emitted, act.emitted);
				errors++;
			end
			if (act.emit_value !== exp_res.emit_value) begin
				$display("%t: emit_value expected %h actual %h", $realtime,
					exp_res.emit_value, act.emit_value);
				errors++;
			end
			if (act.top_value !== exp_res.top_value) begin
				$display("%t: top_value expected %h actual %h", $realtime,
					exp_res.top_value, act.top_value);
				errors++;
			end
			if (act.stack_level !== exp_res.stack_level) begin
				$display("%t: stack_level expected %0d actual %0d", $realtime,
					exp_res.stack_level, act.stack_level);
				errors++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 400000;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	cmd_item_t cmd_item;
	logic      res_valid;
	logic      res_ready;
	res_item_t res_item;

	stack_scoreboard sb;
	int          burst_left;
	int unsigned cycle_count;
	bit          stall_run;

	stack_machine_execute_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Check results and advance the receiver's stall pattern
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(res_item);
		if (stall_run)
			res_ready <= 1'b1;
		else
			res_ready <= ($urandom_range(0, 3) != 0);
	end

	// Swap between stall-free stretches and random stalls
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_run <= ~stall_run;
	end

	// End the run on timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Present one request, hold it until accepted, note it
	task automatic send_request(logic [3:0] cmd, logic [31:0] opd);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_valid <= 1'b1;
		cmd_item <= '{cmd: cmd, operand: opd};
		do
			@(posedge clk);
		while (!cmd_ready);
		sb.note_request('{cmd: cmd, operand: opd});
	endtask

	// Hold off until every expected result has arrived
	task automatic drain_results();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 4);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_index();
		case ($urandom_range(0, 9))
			0: return -$urandom_range(1, 5);
			1: return $urandom;
			2: return sb.level + $urandom_range(0, 2);
			3: return (sb.level > 0) ? sb.level - 1 : 0;
			default: return $urandom_range(0, (sb.level > 1) ? sb.level - 1 : 1);
		endcase
	endfunction

	initial begin
		logic [3:0] op;
		sb = new();
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_item = '0;
		res_ready = 1'b0;
		stall_run = 1'b0;
		cycle_count = 0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-stack errors, then each operation and edge value
		send_request(OP_DUP, 0);
		send_request(OP_EMIT, 0);
		send_request(OP_SLIDE, 0);
		send_request(OP_SLIDE, 3);
		send_request(OP_ADD, 0);
		send_request(OP_PUSH, 32'h8000_0000);
		send_request(OP_PUSH, 32'hffff_ffff);
		send_request(OP_DIV, 0);
		send_request(OP_PUSH, 32'h8000_0000);
		send_request(OP_PUSH, 32'hffff_ffff);
		send_request(OP_MOD, 0);
		send_request(OP_PUSH, 0);
		send_request(OP_DIV, 0);
		send_request(OP_PUSH, 32'h7fff_ffff);
		send_request(OP_SWAP, 0);
		send_request(OP_COPY, 32'hffff_ffff);
		send_request(OP_COPY, 2);
		send_request(OP_COPY, 1);
		send_request(OP_SLIDE, 32'h8000_0000);
		send_request(OP_SLIDE, 1);
		send_request(OP_MUL, 0);
		send_request(OP_SUB, 0);
		send_request(OP_DISCARD, 0);
		send_request(4'd13, 32'h1234_5678);
		send_request(4'd15, 0);
		drain_results();

		// Random instruction mix weighted toward well-formed sequences
		for (int i = 0; i < 625; i++) begin
			if (i == 300)
				drain_results();
			if (sb.level < 3 || $urandom_range(0, 5) == 0)
				op = OP_PUSH;
			else
				op = 4'($urandom_range(0, 15));
			case (op)
				OP_PUSH: send_request(op, pick_value());
				OP_COPY, OP_SLIDE: send_request(op, pick_index());
				default: send_request(op, $urandom);
			endcase
		end

		drain_results();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sme_pkg.sv
hdl/sme_front.sv
hdl/sme_ram.sv
hdl/sme_divider.sv
hdl/sme_back.sv
hdl/stack_machine_execute_unit.sv
tb/tb_stack_machine_execute_unit.sv
